/* design/mm3_pkg.sv */
`timescale 1ns / 1ps

package mm3_pkg;

  // Body mixing constants
  localparam logic [31:0] MIX_C1   = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2   = 32'h1b873593;
  localparam logic [31:0] STEP_ADD = 32'he6546b64;

  // Finalizer constants
  localparam logic [31:0] FIN_M1 = 32'h85ebca6b;
  localparam logic [31:0] FIN_M2 = 32'hc2b2ae35;

  // Byte counts of one word
  localparam logic [2:0] BYTES_NONE = 3'd0;
  localparam logic [2:0] BYTES_ONE  = 3'd1;
  localparam logic [2:0] BYTES_TWO  = 3'd2;
  localparam logic [2:0] BYTES_3    = 3'd3;
  localparam logic [2:0] BYTES_FULL = 3'd4;

  // Queue between mixer and hash engine
  localparam int          Q_DEPTH = 4;
  localparam int          Q_PTR_W = $clog2(Q_DEPTH);
  localparam int          Q_CNT_W = $clog2(Q_DEPTH + 1);
  localparam logic [Q_CNT_W-1:0] Q_FULL = Q_CNT_W'(Q_DEPTH);

  // Mixed word as it leaves the front part
  typedef struct packed {
    logic [31:0] k;
    logic [2:0]  count;
    logic        last;
  } mix_item_t;

  function automatic logic [31:0] rotl15(input logic [31:0] v);
    rotl15 = {v[16:0], v[31:17]};
  endfunction

  function automatic logic [31:0] rotl13(input logic [31:0] v);
    rotl13 = {v[18:0], v[31:19]};
  endfunction

endpackage

/* design/mm3_in_if.sv */
`timescale 1ns / 1ps

interface mm3_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic [2:0]  byte_count;
  logic        last;

  modport source (output valid, output word, output byte_count, output last, input ready);
  modport sink (input valid, input word, input byte_count, input last, output ready);
endinterface

/* design/mm3_out_if.sv */
`timescale 1ns / 1ps

interface mm3_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash;

  modport source (output valid, output hash, input ready);
  modport sink (input valid, input hash, output ready);
endinterface

/* design/murmur3_32_stream_hash.sv */
`timescale 1ns / 1ps
// Path of the last item of a key to its result: first mixer multiply at the transfer edge,
//   then second mixer multiply, queue write, hash update, two finalizer multiply stages and
//   the output register, each registered; back-pressure can stall any of them.
// Throughput: one item per cycle unless stalled; only the shift-add hash update recurs.
// The 4-entry queue lets the mixer keep taking items while the result side is stalled.
// Reset (rst_n low, synchronous): seed clears to zero, no key is open, all stages empty.

module murmur3_32_stream_hash (
  input  logic        clk,
  input  logic        rst_n,
  mm3_in_if.sink      in_ch,
  mm3_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  logic [31:0]        seed_val_r;
  logic               q_in_valid, q_in_ready;
  mm3_pkg::mix_item_t q_in_item;
  logic               q_out_valid, q_out_ready;
  mm3_pkg::mix_item_t q_out_item;

  // Seed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_val_r <= 32'h0;
    end else if (cfg_we) begin
      seed_val_r <= cfg_wdata;
    end
  end

  mm3_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (q_in_valid),
    .push_ready (q_in_ready),
    .push_item  (q_in_item)
  );

  mm3_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_in_valid),
    .push_ready (q_in_ready),
    .push_item  (q_in_item),
    .pop_valid  (q_out_valid),
    .pop_ready  (q_out_ready),
    .pop_item   (q_out_item)
  );

  mm3_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .seed      (seed_val_r),
    .pop_valid (q_out_valid),
    .pop_ready (q_out_ready),
    .pop_item  (q_out_item),
    .out_ch    (out_ch)
  );

endmodule

/* design/mm3_front.sv */
`timescale 1ns / 1ps

module mm3_front (
  input  logic                clk,
  input  logic                rst_n,
  mm3_in_if.sink              in_ch,
  output logic                push_valid,
  input  logic                push_ready,
  output mm3_pkg::mix_item_t  push_item
);

  logic              a_v_r, a_v_nxt;
  logic [31:0]       a_k_r;
  logic [2:0]        a_cnt_r;
  logic              a_last_r;
  logic              b_v_r, b_v_nxt;
  logic [31:0]       b_k_r;
  logic [2:0]        b_cnt_r;
  logic              b_last_r;
  logic              a_ready;
  logic              b_ready;
  logic [2:0]        cnt;
  logic [31:0]       masked;
  logic              in_xfer;

  // Stage handshakes: a stage moves when empty or when its content moves on
  assign b_ready      = !b_v_r || push_ready;
  assign a_ready      = !a_v_r || b_ready;
  assign in_ch.ready  = a_ready;
  assign in_xfer      = in_ch.valid && a_ready;

  // Normalize the count: only a last item may be short, and never above four
  always_comb begin
    if (!in_ch.last || in_ch.byte_count > mm3_pkg::BYTES_FULL) begin
      cnt = mm3_pkg::BYTES_FULL;
    end else begin
      cnt = in_ch.byte_count;
    end
  end

  // Drop bytes beyond the count
  always_comb begin
    case (cnt)
      mm3_pkg::BYTES_NONE: masked = 32'h0000_0000;
      mm3_pkg::BYTES_ONE:  masked = {24'h0, in_ch.word[7:0]};
      mm3_pkg::BYTES_TWO:  masked = {16'h0, in_ch.word[15:0]};
      mm3_pkg::BYTES_3:    masked = {8'h0, in_ch.word[23:0]};
      default:             masked = in_ch.word;
    endcase
  end

  assign a_v_nxt = a_ready ? in_ch.valid : a_v_r;
  assign b_v_nxt = b_ready ? a_v_r : b_v_r;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      a_v_r <= a_v_nxt;
      b_v_r <= b_v_nxt;
    end
  end

  // First multiply
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_k_r    <= masked * mm3_pkg::MIX_C1;
      a_cnt_r  <= cnt;
      a_last_r <= in_ch.last;
    end
  end

  // Rotate and second multiply
  always_ff @(posedge clk) begin
    if (a_v_r && b_ready) begin
      b_k_r    <= mm3_pkg::rotl15(a_k_r) * mm3_pkg::MIX_C2;
      b_cnt_r  <= a_cnt_r;
      b_last_r <= a_last_r;
    end
  end

  assign push_valid      = b_v_r;
  assign push_item.k     = b_k_r;
  assign push_item.count = b_cnt_r;
  assign push_item.last  = b_last_r;

endmodule

/* design/mm3_queue.sv */
`timescale 1ns / 1ps

module mm3_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  mm3_pkg::mix_item_t  push_item,
  output logic                pop_valid,
  input  logic                pop_ready,
  output mm3_pkg::mix_item_t  pop_item
);

  mm3_pkg::mix_item_t               mem_r [mm3_pkg::Q_DEPTH];
  logic [mm3_pkg::Q_PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [mm3_pkg::Q_PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [mm3_pkg::Q_CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                             push;
  logic                             pop;

  assign push_ready = (cnt_r != mm3_pkg::Q_FULL);
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == mm3_pkg::Q_FULL |-> !push)
    else $error("queue written while full");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r != '0)
    else $error("queue count lost a transfer");

endmodule

/* design/mm3_back.sv */
`timescale 1ns / 1ps

module mm3_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [31:0]         seed,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  mm3_pkg::mix_item_t  pop_item,
  mm3_out_if.source           out_ch
);

  logic        open_r, open_nxt;
  logic [31:0] h_r;
  logic [31:0] tot_r;
  logic        f0_v_r, f0_v_nxt;
  logic [31:0] f0_r;
  logic        f1_v_r, f1_v_nxt;
  logic [31:0] f1_r;
  logic        f2_v_r, f2_v_nxt;
  logic [31:0] f2_r;
  logic        o_v_r, o_v_nxt;
  logic [31:0] o_r;
  logic        o_ready, f2_ready, f1_ready, f0_ready;
  logic        pop;
  logic [31:0] h_base, t_base, hx, hr, h_new, t_new;
  logic [31:0] f0_s, f1_s, f2_s;

  // Finalizer stage handshakes
  assign o_ready  = !o_v_r || out_ch.ready;
  assign f2_ready = !f2_v_r || o_ready;
  assign f1_ready = !f1_v_r || f2_ready;
  assign f0_ready = !f0_v_r || f1_ready;

  // Hold a last item until the finalizer has room
  assign pop_ready = !pop_item.last || f0_ready;
  assign pop       = pop_valid && pop_ready;

  // Hash update: a new key starts from the seed
  always_comb begin
    h_base = open_r ? h_r : seed;
    t_base = open_r ? tot_r : 32'h0;
    hx     = h_base ^ pop_item.k;
    hr     = mm3_pkg::rotl13(hx);
    if (pop_item.count == mm3_pkg::BYTES_FULL) begin
      h_new = {hr[29:0], 2'b00} + hr + mm3_pkg::STEP_ADD;
    end else begin
      h_new = hx;
    end
    t_new = t_base + {29'h0, pop_item.count};
  end

  assign open_nxt = pop ? !pop_item.last : open_r;
  assign f0_v_nxt = f0_ready ? (pop && pop_item.last) : f0_v_r;
  assign f1_v_nxt = f1_ready ? f0_v_r : f1_v_r;
  assign f2_v_nxt = f2_ready ? f1_v_r : f2_v_r;
  assign o_v_nxt  = o_ready ? f2_v_r : o_v_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      f0_v_r <= 1'b0;
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      open_r <= open_nxt;
      f0_v_r <= f0_v_nxt;
      f1_v_r <= f1_v_nxt;
      f2_v_r <= f2_v_nxt;
      o_v_r  <= o_v_nxt;
    end
  end

  // Running hash and length
  always_ff @(posedge clk) begin
    if (pop) begin
      h_r   <= h_new;
      tot_r <= t_new;
    end
  end

  // Finalizer data path
  assign f0_s = f0_r ^ {16'h0, f0_r[31:16]};
  assign f1_s = f1_r ^ {13'h0, f1_r[31:13]};
  assign f2_s = f2_r ^ {16'h0, f2_r[31:16]};

  always_ff @(posedge clk) begin
    if (pop && pop_item.last && f0_ready) begin
      f0_r <= h_new ^ t_new;
    end
    if (f0_v_r && f1_ready) begin
      f1_r <= f0_s * mm3_pkg::FIN_M1;
    end
    if (f1_v_r && f2_ready) begin
      f2_r <= f1_s * mm3_pkg::FIN_M2;
    end
    if (f2_v_r && o_ready) begin
      o_r <= f2_s;
    end
  end

  assign out_ch.valid = o_v_r;
  assign out_ch.hash  = o_r;

  a_last_enters_fin: assert property (@(posedge clk) disable iff (!rst_n)
    pop && pop_item.last |=> f0_v_r)
    else $error("last item did not enter the finalizer");

  a_key_closes_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(open_r) && $past(rst_n) |-> $past(pop && pop_item.last))
    else $error("key closed without a last item");

endmodule
